>>> rtl/huffman_code_bit_packer_macros.svh
// Assertion helpers shared by the packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// Same-cycle implication.
`define HCBP_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbp assertion failed");

// Next-cycle implication.
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbp assertion failed");

`endif

>>> rtl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int BYTE_BITS = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SYMBOL = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage

>>> rtl/huffman_code_bit_packer.sv
// channel  | valid      | stall      | payload
// ---------+------------+------------+----------------------------------------------
// item in  | item_valid | item_stall | kind symbol code_word code_length end_of_message
// byte out | byte_valid | byte_stall | out_byte final_byte symbol_count
//
// A load request writes the code table when accepted; a symbol request is merged into the
// bit accumulator, then the emitter sends each byte it completes (up to five with a flush).
// The rate is set by the byte emitter, which sends at most one byte per cycle.
// The code table is a synchronous memory read, registered when the symbol is accepted.
// Reset (rst, synchronous) clears the pipeline and message state, not the table.
// byte_stall holds the output register; the emitter and the read stage back up behind it.
`include "huffman_code_bit_packer_macros.svh"

module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN  = 32,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        kind,
  input  logic [7:0]  symbol,
  input  logic [31:0] code_word,
  input  logic [5:0]  code_length,
  input  logic        end_of_message,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  out_byte,
  output logic        final_byte,
  output logic [31:0] symbol_count
);

  localparam int LEN_MAX = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                             : hcbp_pkg::CODE_W;
  localparam int ACC_W   = LEN_MAX + hcbp_pkg::BYTE_BITS - 1;
  localparam int CNT_W   = $clog2(ACC_W + 1);
  localparam int AW      = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  hcbp_pkg::entry_t mem [ALPHABET_SIZE];

  logic                  item_accept;
  logic                  sym_in_range;
  logic [AW-1:0]         addr;
  logic [5:0]            len_sat;

  logic                  s1_valid;
  logic                  s1_in_range;
  logic                  s1_eom;
  hcbp_pkg::entry_t      rd_entry;

  logic [ACC_W-1:0]      acc, acc_next;
  logic [CNT_W-1:0]      bit_count, bit_count_next;
  logic                  eom_pending, eom_pending_next;
  logic [31:0]           symbols_seen, symbols_seen_next;

  logic                  slot_free;
  logic                  emit_full;
  logic                  busy;
  logic                  merge;
  logic                  do_emit;
  logic                  fin;
  logic [5:0]            code_len;
  logic [63:0]           mask64;
  logic [31:0]           code_bits;
  logic [7:0]            pend_mask;
  logic [6:0]            pend;
  logic [ACC_W-1:0]      merged;
  logic [CNT_W-1:0]      shift;
  logic [7:0]            full_byte;
  logic [7:0]            flush_byte;

  assign item_accept  = item_valid && !item_stall;
  assign item_stall   = s1_valid && !merge;
  assign sym_in_range = {1'b0, symbol} < 9'(ALPHABET_SIZE);
  assign addr         = symbol[AW-1:0];
  assign len_sat      = (code_length > 6'(LEN_MAX)) ? 6'(LEN_MAX) : code_length;

  // table write and read
  always_ff @(posedge clk) begin
    if (item_accept && kind == hcbp_pkg::KIND_LOAD && sym_in_range) begin
      mem[addr] <= '{len: len_sat, code: code_word};
    end
    if (item_accept && kind == hcbp_pkg::KIND_SYMBOL) begin
      rd_entry <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept && kind == hcbp_pkg::KIND_SYMBOL) begin
      s1_valid <= 1'b1;
    end else if (merge) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept && kind == hcbp_pkg::KIND_SYMBOL) begin
      s1_in_range <= sym_in_range;
      s1_eom      <= end_of_message;
    end
  end

  always_comb begin
    slot_free  = !byte_valid || !byte_stall;
    emit_full  = bit_count >= CNT_W'(hcbp_pkg::BYTE_BITS);
    busy       = emit_full || eom_pending;
    merge      = s1_valid && !busy;
    do_emit    = busy && slot_free;
    fin        = eom_pending && (!emit_full || bit_count == CNT_W'(hcbp_pkg::BYTE_BITS));

    code_len   = s1_in_range ? rd_entry.len : 6'd0;
    mask64     = (64'd1 << code_len) - 64'd1;
    code_bits  = rd_entry.code & mask64[31:0];
    pend_mask  = (8'd1 << bit_count[2:0]) - 8'd1;
    pend       = acc[6:0] & pend_mask[6:0];
    merged     = (ACC_W'(pend) << code_len) | ACC_W'(code_bits);

    shift      = bit_count - CNT_W'(hcbp_pkg::BYTE_BITS);
    full_byte  = 8'(acc >> shift);
    flush_byte = acc[7:0] << (4'(hcbp_pkg::BYTE_BITS) - {1'b0, bit_count[2:0]});
  end

  always_comb begin
    acc_next          = acc;
    bit_count_next    = bit_count;
    eom_pending_next  = eom_pending;
    symbols_seen_next = symbols_seen;
    if (merge) begin
      acc_next          = merged;
      bit_count_next    = bit_count + CNT_W'(code_len);
      eom_pending_next  = s1_eom;
      symbols_seen_next = symbols_seen + 32'd1;
    end else if (do_emit) begin
      if (fin) begin
        bit_count_next    = '0;
        eom_pending_next  = 1'b0;
        symbols_seen_next = '0;
      end else begin
        bit_count_next = shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count    <= '0;
      eom_pending  <= 1'b0;
      symbols_seen <= '0;
      acc          <= '0;
    end else begin
      bit_count    <= bit_count_next;
      eom_pending  <= eom_pending_next;
      symbols_seen <= symbols_seen_next;
      acc          <= acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (do_emit) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_byte     <= emit_full ? full_byte : flush_byte;
      final_byte   <= fin;
      symbol_count <= fin ? symbols_seen : 32'd0;
    end
  end

  `HCBP_ASSERT(a_count_bound, clk, rst, 1'b1, bit_count <= CNT_W'(ACC_W))
  `HCBP_ASSERT(a_count_final_only, clk, rst, byte_valid && !final_byte, symbol_count == 32'd0)
  `HCBP_ASSERT_NEXT(a_restart, clk, rst, do_emit && fin, bit_count == '0 && symbols_seen == '0 && !eom_pending)
  `HCBP_ASSERT_NEXT(a_hold_read, clk, rst, s1_valid && !merge, s1_valid && $stable(rd_entry))

endmodule
